@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SACL_ASSERT(lbl, clk, rst, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SACL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/sacl_pkg.sv @@
package sacl_pkg;

    localparam int ADDR_W             = 64;
    localparam int CNT_W              = 32;
    localparam int SET_OUT_W          = 6;
    localparam int WAY_OUT_W          = 2;
    localparam int CFG_IDX_W          = 2;
    localparam int CFG_DATA_W         = 6;
    localparam int SH_W               = 7;

    localparam int DEF_MAX_INDEX_BITS = 6;
    localparam int DEF_NUM_WAYS       = 4;

    localparam logic [2:0] RST_INDEX_BITS  = 3'd6;
    localparam logic [5:0] RST_OFFSET_BITS = 6'd4;
    localparam logic [2:0] RST_ACTIVE_WAYS = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INDEX_BITS  = 2'd0,
        REG_OFFSET_BITS = 2'd1,
        REG_ACTIVE_WAYS = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } t_outcome;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    typedef struct packed {
        t_outcome              outcome;
        logic [WAY_OUT_W-1:0]  way_used;
    } t_upd_status;

endpackage

@@ rtl/sacl_if.sv @@
interface sacl_in_if;
    import sacl_pkg::*;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

interface sacl_out_if;
    import sacl_pkg::*;
    logic                 valid;
    logic                 ready;
    t_outcome             outcome;
    logic [SET_OUT_W-1:0] set_number;
    logic [ADDR_W-1:0]    line_tag;
    logic [WAY_OUT_W-1:0] way_used;
    logic [ADDR_W-1:0]    evicted_tag;
    logic [CNT_W-1:0]     hit_total;
    logic [CNT_W-1:0]     miss_total;
    logic [CNT_W-1:0]     eviction_total;

    modport source (output valid, output outcome, output set_number, output line_tag,
                    output way_used, output evicted_tag, output hit_total,
                    output miss_total, output eviction_total, input ready);
    modport sink   (input valid, input outcome, input set_number, input line_tag,
                    input way_used, input evicted_tag, input hit_total,
                    input miss_total, input eviction_total, output ready);
endinterface

interface sacl_cfg_if;
    import sacl_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

@@ rtl/sacl_ram.sv @@
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/sacl_update.sv @@
module sacl_update #(
    parameter int NUM_WAYS = sacl_pkg::DEF_NUM_WAYS,
    parameter int AGE_W    = 2,
    localparam int ENT_W   = 1 + sacl_pkg::ADDR_W + AGE_W,
    localparam int ROW_W   = NUM_WAYS * ENT_W
) (
    input  logic [ROW_W-1:0]            i_row,
    input  logic [sacl_pkg::ADDR_W-1:0] i_tag,
    input  logic [NUM_WAYS-1:0]         i_active,
    output logic [ROW_W-1:0]            o_row,
    output sacl_pkg::t_upd_status       o_status,
    output logic [sacl_pkg::ADDR_W-1:0] o_evicted_tag
);
    import sacl_pkg::*;

    localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(NUM_WAYS - 1);

    logic              valid  [NUM_WAYS];
    logic [ADDR_W-1:0] tag    [NUM_WAYS];
    logic [AGE_W-1:0]  age    [NUM_WAYS];
    logic [NUM_WAYS-1:0] match, empty, victim;
    logic              hit, fill, evict;
    logic [WAY_W-1:0]  way;
    logic [AGE_W-1:0]  way_age;
    logic              bump;

    always_comb begin
        for (int i = 0; i < NUM_WAYS; i++) begin
            valid[i] = i_row[i*ENT_W];
            tag[i]   = i_row[i*ENT_W + 1 +: ADDR_W];
            age[i]   = i_row[i*ENT_W + 1 + ADDR_W +: AGE_W];
        end

        // Victim is the oldest active way, lowest number on a tie.
        for (int i = 0; i < NUM_WAYS; i++) begin
            match[i]  = i_active[i] && valid[i] && (tag[i] == i_tag);
            empty[i]  = i_active[i] && !valid[i];
            victim[i] = i_active[i];
            for (int j = 0; j < NUM_WAYS; j++) begin
                if (i_active[j] && j < i && !(age[j] < age[i])) begin
                    victim[i] = 1'b0;
                end
                if (i_active[j] && j > i && !(age[j] <= age[i])) begin
                    victim[i] = 1'b0;
                end
            end
        end

        hit   = |match;
        fill  = !hit && (|empty);
        evict = !hit && !(|empty);

        way = '0;
        for (int i = NUM_WAYS - 1; i >= 0; i--) begin
            if (hit ? match[i] : (fill ? empty[i] : victim[i])) begin
                way = WAY_W'(i);
            end
        end
        way_age = age[way];

        o_evicted_tag = evict ? tag[way] : '0;
        o_status.outcome  = hit ? OUT_HIT : (fill ? OUT_FILL : OUT_EVICT);
        o_status.way_used = WAY_OUT_W'(way);

        o_row = i_row;
        for (int i = 0; i < NUM_WAYS; i++) begin
            bump = i_active[i] && valid[i] && (WAY_W'(i) != way)
                   && (fill || (age[i] < way_age));
            if (WAY_W'(i) == way) begin
                o_row[i*ENT_W + 1 + ADDR_W +: AGE_W] = '0;
                if (!hit) begin
                    o_row[i*ENT_W]              = 1'b1;
                    o_row[i*ENT_W + 1 +: ADDR_W] = i_tag;
                end
            end else if (bump && (age[i] < AGE_MAX)) begin
                o_row[i*ENT_W + 1 + ADDR_W +: AGE_W] = age[i] + 1'b1;
            end
        end
    end
endmodule

@@ rtl/set_assoc_cache_lru_lookup.sv @@
// Set-associative cache directory with least-recently-used replacement.
// The input channel carries one byte address per beat. The address is split
// into offset, set number and tag by the index_bits and offset_bits registers,
// and the active ways of that set are searched for the tag. Each input beat
// yields exactly one output beat with the outcome (hit, fill or eviction),
// the set number, the tag, the way used, the evicted tag and the running hit,
// miss and eviction totals.
// The configuration channel is always ready; registers are meant to be
// written only while no access is in flight. It does not flush the cache.
// Pipeline: the set row is read from the directory RAM at the
// edge that accepts the address; in the lookup state all ways are compared,
// and once the output register is free the updated row is written back
// and the output register loads. A new address is taken only after the
// row of the last one has been written back, since a following access to
// the same set must see it.
// After reset the block sweeps the directory RAM and zeroes every row, one
// set per cycle, with input ready held low.
// A stalled output holds its beat; one more address may be accepted and is
// then held in the lookup stage until the output register frees up.
module set_assoc_cache_lru_lookup #(
    parameter int MAX_INDEX_BITS = sacl_pkg::DEF_MAX_INDEX_BITS,
    parameter int NUM_WAYS       = sacl_pkg::DEF_NUM_WAYS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sacl_in_if.sink    i_in,
    sacl_out_if.source o_out,
    sacl_cfg_if.sink   i_cfg
);
    import sacl_pkg::*;

    localparam int AGE_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int ENT_W    = 1 + ADDR_W + AGE_W;
    localparam int ROW_W    = NUM_WAYS * ENT_W;
    localparam int NUM_SETS = 1 << MAX_INDEX_BITS;
    localparam int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

    // Configuration registers.
    logic [2:0] r_index_bits;
    logic [5:0] r_offset_bits;
    logic [2:0] r_active_ways;

    // Control.
    t_state           r_state, n_state;
    logic [SET_W-1:0] r_clr_addr;
    logic             r_out_valid;

    // Item under lookup.
    logic [ADDR_W-1:0] r_tag;
    logic [SET_W-1:0]  r_set;

    // Output beat and running totals.
    t_outcome             r_outcome;
    logic [SET_OUT_W-1:0] r_set_num;
    logic [ADDR_W-1:0]    r_line_tag;
    logic [WAY_OUT_W-1:0] r_way_used;
    logic [ADDR_W-1:0]    r_evicted;
    logic [CNT_W-1:0]     r_hits, r_misses, r_evicts;

    // Address split for the incoming beat.
    logic [SH_W-1:0]   idx_eff;
    logic [SH_W-1:0]   tag_shamt;
    logic [ADDR_W-1:0] off_shifted;
    logic [SET_W-1:0]  set_calc;
    logic [ADDR_W-1:0] tag_calc;

    // RAM and update logic hookup.
    logic             ram_we, ram_re;
    logic [SET_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata, ram_rdata, upd_row;
    logic [NUM_WAYS-1:0] active;
    t_upd_status       upd_status;
    logic [ADDR_W-1:0] upd_evicted;
    logic              in_fire, load;

    assign in_fire = i_in.valid && i_in.ready;

    // An index width above the supported maximum acts as the maximum. The
    // tag shift can pass bit 63; the tag is then zero.
    always_comb begin
        idx_eff = ({4'b0, r_index_bits} > SH_W'(MAX_INDEX_BITS))
                  ? SH_W'(MAX_INDEX_BITS) : {4'b0, r_index_bits};
        tag_shamt   = idx_eff + {1'b0, r_offset_bits};
        off_shifted = i_in.address >> r_offset_bits;
        tag_calc    = (tag_shamt >= SH_W'(ADDR_W)) ? '0 : (i_in.address >> tag_shamt);
        for (int k = 0; k < SET_W; k++) begin
            set_calc[k] = off_shifted[k] && (k < int'(idx_eff));
        end
    end

    // Way 0 is always in use; a register value above the way count uses all.
    always_comb begin
        for (int i = 0; i < NUM_WAYS; i++) begin
            active[i] = (i == 0) || (i < int'(r_active_ways));
        end
    end

    always_comb begin
        n_state    = r_state;
        i_in.ready = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = r_set;
        ram_wdata  = upd_row;
        load       = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
                if (r_clr_addr == SET_W'(NUM_SETS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                i_in.ready = 1'b1;
                ram_re     = in_fire;
                if (in_fire) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                // The read row stays in the RAM output register while waiting.
                if (!r_out_valid || o_out.ready) begin
                    ram_we  = 1'b1;
                    load    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (r_state == ST_CLEAR) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Configuration writes; indexes beyond the register list are dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_bits  <= RST_INDEX_BITS;
            r_offset_bits <= RST_OFFSET_BITS;
            r_active_ways <= RST_ACTIVE_WAYS;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.reg_index))
                REG_INDEX_BITS:  r_index_bits  <= i_cfg.wr_data[2:0];
                REG_OFFSET_BITS: r_offset_bits <= i_cfg.wr_data;
                REG_ACTIVE_WAYS: r_active_ways <= i_cfg.wr_data[2:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_tag <= tag_calc;
            r_set <= set_calc;
        end
    end

    sacl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_dir_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (set_calc),
        .o_rdata (ram_rdata)
    );

    sacl_update #(
        .NUM_WAYS (NUM_WAYS),
        .AGE_W    (AGE_W)
    ) u_update (
        .i_row         (ram_rdata),
        .i_tag         (r_tag),
        .i_active      (active),
        .o_row         (upd_row),
        .o_status      (upd_status),
        .o_evicted_tag (upd_evicted)
    );

    // Output valid and running totals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                if (upd_status.outcome == OUT_HIT) begin
                    r_hits <= r_hits + 1'b1;
                end else begin
                    r_misses <= r_misses + 1'b1;
                end
                if (upd_status.outcome == OUT_EVICT) begin
                    r_evicts <= r_evicts + 1'b1;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_outcome  <= upd_status.outcome;
            r_way_used <= upd_status.way_used;
            r_set_num  <= SET_OUT_W'(r_set);
            r_line_tag <= r_tag;
            r_evicted  <= upd_evicted;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.outcome        = r_outcome;
    assign o_out.set_number     = r_set_num;
    assign o_out.line_tag       = r_line_tag;
    assign o_out.way_used       = r_way_used;
    assign o_out.evicted_tag    = r_evicted;
    assign o_out.hit_total      = r_hits;
    assign o_out.miss_total     = r_misses;
    assign o_out.eviction_total = r_evicts;
endmodule

@@ rtl/sacl_checker.sv @@
`include "assert_macros.svh"

module sacl_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input sacl_pkg::t_outcome         i_outcome,
    input logic [sacl_pkg::ADDR_W-1:0] i_line_tag,
    input logic [sacl_pkg::ADDR_W-1:0] i_evicted_tag
);
    import sacl_pkg::*;

    // The directory clear pass keeps the input closed right after reset.
    `SACL_ASSERT_ALWAYS(a_clear_after_reset, i_clk, !i_rst_n |=> !i_in_ready, "input ready during clear")

    // A set row is read and written back before the next address is taken.
    `SACL_ASSERT(a_one_in_flight, i_clk, !i_rst_n, (i_in_valid && i_in_ready) |=> !i_in_ready, "second beat taken during lookup")

    // Only an eviction reports a removed tag.
    `SACL_ASSERT(a_evict_tag_zero, i_clk, !i_rst_n, (i_out_valid && (i_outcome != OUT_EVICT)) |-> (i_evicted_tag == '0), "evicted tag set without eviction")

    // A stalled result beat holds.
    `SACL_ASSERT(a_out_hold, i_clk, !i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_line_tag) && $stable(i_outcome)), "stalled result beat changed")
endmodule

bind set_assoc_cache_lru_lookup sacl_checker u_sacl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_outcome     (o_out.outcome),
    .i_line_tag    (o_out.line_tag),
    .i_evicted_tag (o_out.evicted_tag)
);

@@ test/set_assoc_cache_lru_lookup_tb.sv @@
module set_assoc_cache_lru_lookup_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sacl_pkg::*;

    // Directory geometry as built with the default parameters.
    localparam int NUM_SETS      = 1 << DEF_MAX_INDEX_BITS;
    localparam int NUM_WAYS      = DEF_NUM_WAYS;

    // Run shape. The cycle limit is several times the slowest legal run:
    // about 1800 beats at the longest idle gaps on each side plus the time
    // taken by the block itself, the long receiver hold and the clearing
    // sweep after reset.
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 220;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 4;
    localparam int HOT_TAGS      = 6;
    localparam int HOT_SETS      = 3;

    // Register index with no register behind it; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [ADDR_W-1:0]    ALL_ONES  = '1;

    // Idle patterns for either side of the block.
    localparam int IDLE_NONE   = 0;
    localparam int IDLE_RANDOM = 1;
    localparam int IDLE_SPARSE = 2;

    typedef struct packed {
        t_outcome             outcome;
        logic [SET_OUT_W-1:0] set_number;
        logic [ADDR_W-1:0]    line_tag;
        logic [WAY_OUT_W-1:0] way_used;
        logic [ADDR_W-1:0]    evicted_tag;
        logic [CNT_W-1:0]     hit_total;
        logic [CNT_W-1:0]     miss_total;
        logic [CNT_W-1:0]     eviction_total;
    } lookup_result_t;

    // The scoreboard carries its own copy of the directory: valid bits, tags
    // and recency ranks per set and way, the three running totals and the
    // register values. Every accepted address is looked up here at the time
    // of its input beat, and the expected output beat is queued.
    class lru_lookup_scoreboard;
        logic [2:0]        index_bits;
        logic [5:0]        offset_bits;
        logic [2:0]        active_ways;
        bit                valid_bit [NUM_SETS][NUM_WAYS];
        logic [ADDR_W-1:0] tag_store [NUM_SETS][NUM_WAYS];
        int                rank      [NUM_SETS][NUM_WAYS];
        logic [CNT_W-1:0]  hits;
        logic [CNT_W-1:0]  misses;
        logic [CNT_W-1:0]  evictions;
        lookup_result_t    pending_lookups [$];
        int                failures;

        function new();
            index_bits  = RST_INDEX_BITS;
            offset_bits = RST_OFFSET_BITS;
            active_ways = RST_ACTIVE_WAYS;
            foreach (rank[s, w]) begin
                valid_bit[s][w] = 1'b0;
                tag_store[s][w] = '0;
                rank[s][w]      = 0;
            end
            hits      = '0;
            misses    = '0;
            evictions = '0;
            failures  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_INDEX_BITS:  index_bits  = data[2:0];
                REG_OFFSET_BITS: offset_bits = data;
                REG_ACTIVE_WAYS: active_ways = data[2:0];
                default: ;
            endcase
        endfunction

        // Index bit counts above the built maximum act as the maximum.
        function int set_bits();
            return (index_bits > DEF_MAX_INDEX_BITS) ? DEF_MAX_INDEX_BITS : int'(index_bits);
        endfunction

        // Zero ways acts as one, and anything above the built count as the count.
        function int ways_in_use();
            if (active_ways == 0)
                return 1;
            return (active_ways > NUM_WAYS) ? NUM_WAYS : int'(active_ways);
        endfunction

        // Way w becomes most recent; other valid ways ranked below limit age by one.
        function void make_recent(int set_idx, int ways, int w, int limit);
            for (int i = 0; i < ways; i++) begin
                if (i != w && valid_bit[set_idx][i] && rank[set_idx][i] < limit &&
                    rank[set_idx][i] < NUM_WAYS - 1)
                    rank[set_idx][i]++;
            end
            rank[set_idx][w] = 0;
        endfunction

        function void note_access(logic [ADDR_W-1:0] addr);
            int                s;
            int                b;
            int                ways;
            int                set_idx;
            int                w;
            bit                hit;
            bit                have_empty;
            logic [ADDR_W-1:0] tag;
            logic [ADDR_W-1:0] shifted;
            lookup_result_t    r;

            s    = set_bits();
            b    = offset_bits;
            ways = ways_in_use();
            // Bits shifted in from above bit 63 are zero.
            tag     = (s + b >= ADDR_W) ? '0 : addr >> (s + b);
            shifted = (b >= ADDR_W) ? '0 : addr >> b;
            set_idx = int'(shifted & ((64'd1 << s) - 64'd1));

            hit        = 1'b0;
            have_empty = 1'b0;
            w          = 0;
            r.evicted_tag = '0;

            // The lowest matching way wins when a tag sits in more than one way.
            for (int i = 0; i < ways; i++) begin
                if (!hit && valid_bit[set_idx][i] && tag_store[set_idx][i] == tag) begin
                    hit = 1'b1;
                    w   = i;
                end
            end

            if (hit) begin
                make_recent(set_idx, ways, w, rank[set_idx][w]);
                hits++;
                r.outcome = OUT_HIT;
            end else begin
                misses++;
                for (int i = 0; i < ways; i++) begin
                    if (!have_empty && !valid_bit[set_idx][i]) begin
                        have_empty = 1'b1;
                        w          = i;
                    end
                end
                if (have_empty) begin
                    valid_bit[set_idx][w] = 1'b1;
                    tag_store[set_idx][w] = tag;
                    make_recent(set_idx, ways, w, NUM_WAYS);
                    r.outcome = OUT_FILL;
                end else begin
                    // Oldest way is the victim, lowest way number on a tie.
                    w = 0;
                    for (int i = 1; i < ways; i++) begin
                        if (rank[set_idx][i] > rank[set_idx][w])
                            w = i;
                    end
                    r.evicted_tag         = tag_store[set_idx][w];
                    tag_store[set_idx][w] = tag;
                    make_recent(set_idx, ways, w, rank[set_idx][w]);
                    evictions++;
                    r.outcome = OUT_EVICT;
                end
            end

            r.set_number     = SET_OUT_W'(set_idx);
            r.line_tag       = tag;
            r.way_used       = WAY_OUT_W'(w);
            r.hit_total      = hits;
            r.miss_total     = misses;
            r.eviction_total = evictions;
            pending_lookups.push_back(r);
        endfunction

        function void compare(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(lookup_result_t got);
            lookup_result_t want;
            if (pending_lookups.size() == 0) begin
                $error("result beat with no access outstanding: set %0d tag %0h",
                       got.set_number, got.line_tag);
                failures++;
                return;
            end
            want = pending_lookups.pop_front();
            compare("outcome",        want.outcome,        got.outcome);
            compare("set_number",     want.set_number,     got.set_number);
            compare("line_tag",       want.line_tag,       got.line_tag);
            compare("way_used",       want.way_used,       got.way_used);
            compare("evicted_tag",    want.evicted_tag,    got.evicted_tag);
            compare("hit_total",      want.hit_total,      got.hit_total);
            compare("miss_total",     want.miss_total,     got.miss_total);
            compare("eviction_total", want.eviction_total, got.eviction_total);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    sacl_in_if  in_if ();
    sacl_out_if out_if ();
    sacl_cfg_if cfg_if ();

    set_assoc_cache_lru_lookup DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    lru_lookup_scoreboard board = new();

    // Idle pattern of each side, chosen per phase by the stimulus process.
    int send_mode;
    int recv_mode;
    // Set by the stimulus process to make the receiver hold off once.
    int hold_request;
    int cycle_count;

    // Per-phase pool of tags and sets that the random part keeps returning to,
    // so that hits, fills and evictions all come up often.
    logic [ADDR_W-1:0] hot_tags [HOT_TAGS];
    int unsigned       hot_sets [HOT_SETS];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: the run must end well before this many cycles.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    function automatic int draw_wait(int mode);
        case (mode)
            IDLE_NONE:   return 0;
            IDLE_RANDOM: return $urandom_range(0, 15);
            default:     return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] random64();
        return {$urandom, $urandom};
    endfunction

    // Builds an address with the given tag and set under the current register
    // values; the block offset comes from the low bits of noise.
    function automatic logic [ADDR_W-1:0] compose(input logic [ADDR_W-1:0] tag,
                                                 input int unsigned set_idx,
                                                 input logic [ADDR_W-1:0] noise);
        int                s;
        int                b;
        logic [ADDR_W-1:0] low_mask;
        logic [ADDR_W-1:0] a;
        s        = board.set_bits();
        b        = board.offset_bits;
        low_mask = (b >= ADDR_W) ? '1 : ((64'd1 << b) - 64'd1);
        a        = noise & low_mask;
        if (b < ADDR_W)
            a |= (ADDR_W'(set_idx) & ((64'd1 << s) - 64'd1)) << b;
        if (s + b < ADDR_W)
            a |= tag << (s + b);
        return a;
    endfunction

    // Most accesses revisit the hot pool; the rest are raw addresses and
    // corner patterns.
    function automatic logic [ADDR_W-1:0] random_address();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 72)
            return compose(hot_tags[$urandom_range(0, HOT_TAGS - 1)],
                           hot_sets[$urandom_range(0, HOT_SETS - 1)], random64());
        if (pick < 80)
            return compose(hot_tags[$urandom_range(0, HOT_TAGS - 1)], $urandom, random64());
        if (pick < 95)
            return random64();
        case ($urandom_range(0, 2))
            0:       return ALL_ONES;
            1:       return '0;
            default: return 64'd1 << $urandom_range(0, ADDR_W - 1);
        endcase
    endfunction

    task automatic refresh_pool();
        foreach (hot_tags[i])
            hot_tags[i] = random64();
        if ($urandom_range(0, 1) == 1)
            hot_tags[0] = ALL_ONES;
        foreach (hot_sets[i])
            hot_sets[i] = $urandom_range(0, NUM_SETS - 1);
    endtask

    // One input beat. Valid is lowered only when a gap precedes this beat, so
    // back-to-back beats keep it high without a second assignment in one step.
    task automatic send_address(input logic [ADDR_W-1:0] addr);
        int gap;
        gap = draw_wait(send_mode);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.address <= addr;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        board.note_access(addr);
    endtask

    // Every address yields one result, so the block is idle once the queue
    // of expected results is empty; a few more cycles cover its pipeline.
    task automatic wait_drained();
        while (board.pending_lookups.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= idx;
        cfg_if.wr_data   <= data;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        board.write_reg(idx, data);
    endtask

    // Writes all three registers back to back once the block has gone idle.
    // With poke_spare set, the unused index gets a write first.
    task automatic apply_config(input int ib, input int ob, input int aw,
                                input bit poke_spare = 1'b0);
        in_if.valid <= 1'b0;
        wait_drained();
        if (poke_spare)
            cfg_beat(REG_SPARE, CFG_DATA_W'($urandom));
        cfg_beat(REG_INDEX_BITS, CFG_DATA_W'(ib));
        cfg_beat(REG_OFFSET_BITS, CFG_DATA_W'(ob));
        cfg_beat(REG_ACTIVE_WAYS, CFG_DATA_W'(aw));
        cfg_if.valid <= 1'b0;
    endtask

    // Receiver: draws a stall before each output beat, or takes the long hold
    // when one is requested, then checks the beat against the oldest
    // expectation.
    initial begin : result_sink
        int             stall;
        lookup_result_t got;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = (hold_request > 0) ? hold_request : draw_wait(recv_mode);
            hold_request = 0;
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
            got.outcome        = out_if.outcome;
            got.set_number     = out_if.set_number;
            got.line_tag       = out_if.line_tag;
            got.way_used       = out_if.way_used;
            got.evicted_tag    = out_if.evicted_tag;
            got.hit_total      = out_if.hit_total;
            got.miss_total     = out_if.miss_total;
            got.eviction_total = out_if.eviction_total;
            board.check_result(got);
        end
    end

    initial begin : stimulus
        logic [ADDR_W-1:0] a;
        int                ib;
        int                ob;
        int                aw;

        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.address    <= '0;
        out_if.ready     <= 1'b0;
        cfg_if.valid     <= 1'b0;
        cfg_if.reg_index <= REG_INDEX_BITS;
        cfg_if.wr_data   <= '0;
        send_mode    = IDLE_RANDOM;
        recv_mode    = IDLE_RANDOM;
        hold_request = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset register values: 6 index bits,
        // 4 offset bits, all 4 ways. The first beat waits out the clearing
        // sweep on its own through the ready handshake.
        send_address('0);
        send_address('0);                       // hit on the way just filled
        send_address(ALL_ONES);                 // top set, widest tag
        // Five tags into one set: four fills, then the oldest is evicted.
        for (int t = 1; t <= 5; t++)
            send_address(compose(t, 1, '0));
        // A hit in the middle of the ranks, then a miss that must evict the
        // way that is still oldest, since the hit ages only the more recent ways.
        send_address(compose(3, 1, 64'hF));
        send_address(compose(6, 1, '0));
        send_address(64'h8000_0000_0000_0000);

        // Build the same tag in two ways of one set: fill two ways, shrink to
        // one way so the second tag overwrites way 0, then widen again. The
        // next access matches both ways and must report the lower one.
        apply_config(6, 4, 2);
        send_address(compose(64'hA, 2, '0));
        send_address(compose(64'hB, 2, '0));
        apply_config(6, 4, 1);
        send_address(compose(64'hB, 2, '0));
        apply_config(6, 4, 2);
        send_address(compose(64'hB, 2, '0));

        // Index bits above the maximum act as the maximum, zero ways as one,
        // and tag bits shifted past bit 63 read as zero.
        apply_config(7, 60, 0, 1'b1);
        send_address(ALL_ONES);
        send_address(64'h1000_0000_0000_0000);

        // No index bits and no offset: a single set and the whole address
        // as tag; more than four ways act as four.
        apply_config(0, 0, 7);
        a = random64();
        send_address(a);
        send_address(a);

        // Offset reaching bit 63 leaves one set bit and no tag at all.
        apply_config(6, 63, 4);
        send_address(ALL_ONES);
        send_address(64'h7FFF_FFFF_FFFF_FFFF);

        apply_config(3, 58, 3);
        send_address(ALL_ONES);

        // Random phases, each under its own register setting. The first five are fixed:
        // the reset values, extremes and one middle setting; the rest are drawn.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin ib = RST_INDEX_BITS; ob = RST_OFFSET_BITS; aw = RST_ACTIVE_WAYS; end
                1: begin ib = 0; ob = 0;  aw = 1; end
                2: begin ib = DEF_MAX_INDEX_BITS; ob = 32; aw = NUM_WAYS; end
                3: begin ib = 7; ob = 63; aw = 7; end
                4: begin ib = 2; ob = 12; aw = 3; end
                default: begin
                    ib = $urandom_range(0, 7);
                    ob = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) :
                                                       $urandom_range(0, 40);
                    aw = $urandom_range(0, 7);
                end
            endcase
            apply_config(ib, ob, aw);
            refresh_pool();

            if (phase == 0) begin
                // Full rate on both sides.
                send_mode = IDLE_NONE;
                recv_mode = IDLE_NONE;
            end else if (phase == 2) begin
                // The receiver stops for a long stretch while the sender keeps
                // offering beats, so the block fills up and drops input ready.
                send_mode    = IDLE_NONE;
                recv_mode    = IDLE_SPARSE;
                hold_request = LONG_HOLD;
            end else begin
                send_mode = $urandom_range(IDLE_RANDOM, IDLE_SPARSE);
                recv_mode = $urandom_range(IDLE_RANDOM, IDLE_SPARSE);
            end

            repeat (PHASE_ITEMS)
                send_address(random_address());
        end

        in_if.valid <= 1'b0;
        wait_drained();

        if (board.failures == 0 && board.pending_lookups.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
